// ----- rtl/packed_lu_product_assert.svh -----
// Assertion macros shared by the packed LU product RTL.
`ifndef PACKED_LU_PRODUCT_ASSERT_SVH
`define PACKED_LU_PRODUCT_ASSERT_SVH

`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define PLP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("packed_lu_product: assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define PLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("packed_lu_product: assertion failed");
`else
`define PLP_ASSERT(lbl, clk, rst_n, prop)
`define PLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/plp_pkg.sv -----
// Package with the types and constants of the packed LU product block.
package plp_pkg;

    // Fixed field widths.
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 4;
    localparam int SIZE_W   = 5;
    localparam int TERM_W   = 48;

    // Defaults.
    localparam int MAX_DIM_DEF = 16;
    localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

    // Request kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_NULL
    } t_state;

    // Control that travels with each pair of store reads.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic diag;
    } t_mac_ctl;

endpackage

// ----- rtl/plp_store.sv -----
// Packed LU element store: one write port, two registered read ports.
module plp_store
    import plp_pkg::*;
#(
    parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
    parameter int AW    = $clog2(MAX_DIM_DEF * MAX_DIM_DEF)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_l_addr,
    input  logic [AW-1:0]     i_u_addr,
    output logic [DATA_W-1:0] o_l_data,
    output logic [DATA_W-1:0] o_u_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_l_data;
    logic [DATA_W-1:0] r_u_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge i_clk) begin
        r_l_data <= mem[i_l_addr];
        r_u_data <= mem[i_u_addr];
    end

    assign o_l_data = r_l_data;
    assign o_u_data = r_u_data;

endmodule

// ----- rtl/plp_mac.sv -----
// Multiply-accumulate pipeline that sums the L times U terms and saturates.
`include "packed_lu_product_assert.svh"
module plp_mac
    import plp_pkg::*;
#(
    parameter int ACC_W = TERM_W + $clog2(MAX_DIM_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_ctl          i_ctl,
    input  logic [DATA_W-1:0] i_l_data,
    input  logic [DATA_W-1:0] i_u_data,
    output logic              o_done,
    output logic [DATA_W-1:0] o_product,
    output logic              o_sat
);

    t_mac_ctl                 r_s1;
    t_mac_ctl                 r_s2;
    logic signed [TERM_W-1:0] r_term;
    logic signed [TERM_W-1:0] n_term;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;
    logic signed [2*DATA_W-1:0] prod;
    logic [ACC_W-DATA_W:0]    acc_top;
    logic                     in_range;

    // Control follows the store read latency, then the term register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= i_ctl;
            r_s2 <= r_s1;
        end
    end

    // One term: the U element itself on the diagonal of L, else the
    // product truncated toward minus infinity to Q32.16.
    always_comb begin
        prod = $signed(i_l_data) * $signed(i_u_data);
        if (r_s1.diag) begin
            n_term = TERM_W'($signed(i_u_data));
        end else begin
            n_term = prod[TERM_W+15:16];
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
    end

    // Accumulator, restarted by the first term of a query.
    always_ff @(posedge i_clk) begin
        if (r_s2.valid) begin
            if (r_s2.first) begin
                r_acc <= ACC_W'(r_term);
            end else begin
                r_acc <= r_acc + ACC_W'(r_term);
            end
        end
    end

    // Done flag: set by the last term, cleared when the next query starts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (r_s2.valid && r_s2.last) begin
            r_done <= 1'b1;
        end else if (i_ctl.valid && i_ctl.first) begin
            r_done <= 1'b0;
        end
    end

    // Saturate to 32 bits: the sum fits when all bits above bit 30 agree.
    always_comb begin
        acc_top  = r_acc[ACC_W-1:DATA_W-1];
        in_range = (&acc_top) || (~|acc_top);
        o_sat    = !in_range;
        if (in_range) begin
            o_product = r_acc[DATA_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_product = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_product = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign o_done = r_done;

    `PLP_ASSERT_NEXT(a_first_loads, i_clk, i_rst_n, r_s2.valid && r_s2.first, r_acc == ACC_W'($past(r_term)))
    `PLP_ASSERT(a_done_idle_pipe, i_clk, i_rst_n, r_done |-> !r_s2.valid)
    `PLP_ASSERT(a_done_source, i_clk, i_rst_n, $rose(r_done) |-> $past(r_s2.valid && r_s2.last))

endmodule

// ----- rtl/packed_lu_product.sv -----
// Top level of the packed LU product block: sequencer, store and MAC.
//
// Holds a matrix in packed LU form (unit lower triangle below the diagonal,
// upper triangle on and above it) and returns elements of L times U.
// Input channel s_axis: tuser is the kind (0 write, 1 query), tdata holds
// row, col and a Q16.16 value. A write stores one element and returns
// nothing; an out-of-range write is dropped. A query returns one item on
// m_axis: tdata is the saturated Q16.16 product, tuser the clip flag.
// A query at (row,col) walks min(row,col)+1 terms, one per cycle, each
// reading two elements from the two read ports of the store. Each term
// passes the store read register, the term register and the accumulator;
// the sum is then loaded into the output register, and only after that
// does the block take the next request. An out-of-range query loads zero
// into the output register and holds off the next request until it is loaded.
// The cfg channel sets the matrix size; it is always ready.
// Reset is synchronous and clears the control state and sets the size to
// 16; the store contents are undefined until written. A stalled result is
// held in the output register; a finished query then waits for it before
// the block takes the next request.
`include "packed_lu_product_assert.svh"
module packed_lu_product
    import plp_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write channel: matrix size.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data,
    // Request stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,   // row[3:0], col[7:4], value[39:8]
    input  logic              s_axis_tuser,   // kind[0]
    // Result stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // product[31:0]
    output logic              m_axis_tuser    // saturated[0]
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int ACC_W  = TERM_W + $clog2(MAX_DIM);
    localparam int SzLim  = (MAX_DIM < 31) ? MAX_DIM : 31;

    t_state              r_state;
    t_state              n_state;
    logic [SIZE_W-1:0]   r_size;
    logic [IDX_W-1:0]    r_row;
    logic [IDX_W-1:0]    r_col;
    logic [IDX_W-1:0]    r_k;
    logic [IDX_W-1:0]    r_last;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_product;
    logic                r_sat;

    logic [SIZE_W-1:0]   eff_n;
    logic [IDX_W-1:0]    in_row;
    logic [IDX_W-1:0]    in_col;
    logic [DATA_W-1:0]   in_value;
    logic                in_ok;
    logic                accept;
    logic                out_free;
    logic                load_out;
    logic                load_null;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       l_addr;
    logic [AW-1:0]       u_addr;
    logic [DATA_W-1:0]   l_data;
    logic [DATA_W-1:0]   u_data;
    t_mac_ctl            mac_ctl;
    logic                mac_done;
    logic [DATA_W-1:0]   mac_product;
    logic                mac_sat;

    // Request fields and range check against the effective size.
    assign in_row   = s_axis_tdata[3:0];
    assign in_col   = s_axis_tdata[7:4];
    assign in_value = s_axis_tdata[39:8];

    always_comb begin
        if (r_size == '0) begin
            eff_n = SIZE_W'(1);
        end else if (r_size > SIZE_W'(SzLim)) begin
            eff_n = SIZE_W'(SzLim);
        end else begin
            eff_n = r_size;
        end
    end

    assign in_ok    = ({1'b0, in_row} < eff_n) && ({1'b0, in_col} < eff_n);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // Size register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RST;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && s_axis_tuser == KIND_QUERY) begin
                    n_state = in_ok ? ST_RUN : ST_NULL;
                end
            end
            ST_RUN: begin
                if (r_k == r_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mac_done && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_NULL: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        mac_ctl       = '0;
        load_out      = 1'b0;
        load_null     = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_RUN: begin
                mac_ctl.valid = 1'b1;
                mac_ctl.first = (r_k == '0);
                mac_ctl.last  = (r_k == r_last);
                mac_ctl.diag  = (r_k == r_row);
            end
            ST_WAIT: load_out = mac_done && out_free;
            ST_NULL: begin
                load_out  = out_free;
                load_null = 1'b1;
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Query indices and term counter.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row  <= in_row;
            r_col  <= in_col;
            r_last <= (in_row < in_col) ? in_row : in_col;
            r_k    <= '0;
        end else if (r_state == ST_RUN) begin
            r_k <= r_k + IDX_W'(1);
        end
    end

    // Store addressing: L element at (row,k), U element at (k,col).
    assign wr_en   = accept && (s_axis_tuser == KIND_WRITE) && in_ok;
    assign wr_addr = AW'(32'(in_row) * 32'(MAX_DIM) + 32'(in_col));
    assign l_addr  = AW'(32'(r_row) * 32'(MAX_DIM) + 32'(r_k));
    assign u_addr  = AW'(32'(r_k) * 32'(MAX_DIM) + 32'(r_col));

    plp_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (in_value),
        .i_l_addr  (l_addr),
        .i_u_addr  (u_addr),
        .o_l_data  (l_data),
        .o_u_data  (u_data)
    );

    plp_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_l_data  (l_data),
        .i_u_data  (u_data),
        .o_done    (mac_done),
        .o_product (mac_product),
        .o_sat     (mac_sat)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_product <= load_null ? '0 : mac_product;
            r_sat     <= load_null ? 1'b0 : mac_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_product;
    assign m_axis_tuser  = r_sat;

    `PLP_ASSERT(a_no_accept_busy, i_clk, i_rst_n, (r_state != ST_IDLE) |-> !s_axis_tready)
    `PLP_ASSERT_NEXT(a_write_stays_idle, i_clk, i_rst_n, accept && (s_axis_tuser == KIND_WRITE), r_state == ST_IDLE)
    `PLP_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n, (r_state == ST_RUN) && (r_k == r_last), r_state == ST_WAIT)

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the packed LU product block.
`timescale 1ns / 1ps

module tb_top;
    import plp_pkg::*;

    localparam int N_DIRECTED  = 29;
    localparam int N_PHASES    = 11;
    localparam int PHASE_ITEMS = 82;
    localparam int STORE_DIM   = 16;

    // One product element as the result stream carries it.
    typedef struct packed {
        logic [31:0] product;
        logic        saturated;
    } product_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_QUERY,
        OP_SIZE
    } op_t;

    // Row of the directed table; result is used only where typed is set.
    typedef struct packed {
        op_t         op;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic        typed;
        product_t    result;
    } vector_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata = '0;   // row[3:0], col[7:4], value[39:8]
    logic              s_axis_tuser = 1'b0; // kind[0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;        // product[31:0]
    logic              m_axis_tuser;        // saturated[0]

    // Shadow of the block state used for prediction.
    logic [31:0]       lu_store [STORE_DIM*STORE_DIM];
    bit                entry_written [STORE_DIM*STORE_DIM];
    logic [SIZE_W-1:0] size_reg = SIZE_RST;

    product_t          pending_products [$];
    product_t          arrived;
    int                mismatch_count = 0;
    int                requests_accepted = 0;
    int                items_in_phase = 0;
    logic              steady_run = 1'b0;
    logic              hold_off = 1'b0;

    vector_t           directed_rows [N_DIRECTED];
    logic [SIZE_W-1:0] phase_sizes [N_PHASES];

    packed_lu_product dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Matrix dimension actually in use for a given register value.
    function automatic int active_dim(logic [SIZE_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > STORE_DIM) return STORE_DIM;
        return int'(raw);
    endfunction

    function automatic longint stored_q16(int r, int c);
        return longint'($signed(lu_store[r*STORE_DIM + c]));
    endfunction

    // Element (r,c) of L times U with a unit diagonal in L, saturated to 32 bits.
    function automatic product_t reconstruct_element(logic [3:0] r, logic [3:0] c);
        product_t res;
        longint   acc;
        longint   term;
        int       n;
        int       last;
        n = active_dim(size_reg);
        res = '0;
        if (r >= n || c >= n) return res;
        last = (r < c) ? r : c;
        acc = 0;
        for (int k = 0; k <= last; k++) begin
            if (k == r) begin
                acc += stored_q16(k, c);
            end else begin
                // Q32.32 product floored to Q32.16.
                term = stored_q16(r, k) * stored_q16(k, c);
                acc += term >>> 16;
            end
        end
        if (acc > 64'sd2147483647) begin
            res.product = 32'h7FFF_FFFF;
            res.saturated = 1'b1;
        end else if (acc < -64'sd2147483648) begin
            res.product = 32'h8000_0000;
            res.saturated = 1'b1;
        end else begin
            res.product = acc[31:0];
        end
        return res;
    endfunction

    // Random Q16.16 value: corner values, small magnitudes or any bit pattern.
    function automatic logic [31:0] pick_q16();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20) begin
            case ($urandom_range(5))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                4: return 32'h0001_0000;
                default: return 32'hFFFF_0000;
            endcase
        end
        if (roll < 60) return 32'(int'($urandom_range(524287)) - 262144);
        return $urandom;
    endfunction

    // Offers one request, waits for its handshake and updates the shadow state.
    task automatic send_request(logic kind, logic [3:0] r, logic [3:0] c,
                                logic [31:0] value, logic typed, product_t typed_result);
        int       n;
        product_t predicted;
        while (!steady_run && $urandom_range(99) < 38) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, c, r};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        requests_accepted++;
        n = active_dim(size_reg);
        if (kind == KIND_WRITE) begin
            if (r < n && c < n) begin
                lu_store[r*STORE_DIM + c] = value;
                entry_written[r*STORE_DIM + c] = 1'b1;
                items_in_phase++;
            end
        end else begin
            predicted = reconstruct_element(r, c);
            pending_products.push_back(typed ? typed_result : predicted);
            items_in_phase++;
        end
    endtask

    // Drains the block, then writes the size register.
    task automatic program_size(logic [SIZE_W-1:0] dim);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_products.size() != 0) @(posedge i_clk);
        // Trailing writes give no result, so allow them time to land.
        repeat (30) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= dim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        size_reg = dim;
    endtask

    // Query that first fills every element it will read and has not yet been written.
    task automatic query_with_fill(logic [3:0] r, logic [3:0] c);
        int last;
        last = (r < c) ? r : c;
        for (int k = 0; k <= last; k++) begin
            if (!entry_written[r*STORE_DIM + k])
                send_request(KIND_WRITE, r, 4'(k), pick_q16(), 1'b0, '0);
            if (!entry_written[k*STORE_DIM + c])
                send_request(KIND_WRITE, 4'(k), c, pick_q16(), 1'b0, '0);
        end
        send_request(KIND_QUERY, r, c, $urandom, 1'b0, '0);
    endtask

    // One random request for the current size; a query comes after any fill writes it needs.
    task automatic random_request();
        int n;
        int roll;
        logic [3:0] r;
        logic [3:0] c;
        n = active_dim(size_reg);
        roll = $urandom_range(99);
        if (roll < 8 && n < STORE_DIM) begin
            // At least one index beyond the active size.
            r = 4'($urandom_range(15));
            c = 4'($urandom_range(15, n));
            if ($urandom_range(1)) begin
                r = c;
                c = 4'($urandom_range(15));
            end
            send_request($urandom_range(1) ? KIND_QUERY : KIND_WRITE, r, c, $urandom,
                         1'b0, '0);
        end else if (roll < 45) begin
            r = 4'($urandom_range(n - 1));
            c = 4'($urandom_range(n - 1));
            send_request(KIND_WRITE, r, c, pick_q16(), 1'b0, '0);
        end else begin
            r = 4'($urandom_range(n - 1));
            c = 4'($urandom_range(n - 1));
            query_with_fill(r, c);
        end
    endtask

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_products.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: product %h saturated %b",
                             m_axis_tdata, m_axis_tuser);
            end else begin
                arrived = pending_products.pop_front();
                if (arrived.product !== m_axis_tdata || arrived.saturated !== m_axis_tuser)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: product exp %h got %h, saturated exp %b got %b",
                                 arrived.product, m_axis_tdata, arrived.saturated,
                                 m_axis_tuser);
                end
            end
        end
    end

    // Result side: random stalls, none during the steady phase, and a full stall during the hold-off.
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_off && (steady_run || $urandom_range(99) >= 38);
    end

    // Long receiver hold-off midway so the block backs up into the request side.
    initial begin
        wait (requests_accepted >= 450);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Watchdog.
    initial begin
        #10_000_000;
        $display("[packed_lu_product] ERROR");
        $finish;
    end

    // Main stimulus.
    initial begin
        directed_rows = '{
            '{OP_WRITE, 4'd0,  4'd0, 32'h7FFF_FFFF, 1'b0, '0},
            '{OP_QUERY, 4'd0,  4'd0, 32'h0,         1'b1, '{32'h7FFF_FFFF, 1'b0}},
            '{OP_WRITE, 4'd0,  4'd0, 32'h8000_0000, 1'b0, '0},
            '{OP_QUERY, 4'd0,  4'd0, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 1'b0}},
            '{OP_WRITE, 4'd0,  4'd0, 32'h0001_0000, 1'b0, '0},
            '{OP_WRITE, 4'd0,  4'd1, 32'h7FFF_FFFF, 1'b0, '0},
            '{OP_WRITE, 4'd1,  4'd0, 32'h7FFF_FFFF, 1'b0, '0},
            '{OP_WRITE, 4'd1,  4'd1, 32'h7FFF_FFFF, 1'b0, '0},
            '{OP_QUERY, 4'd0,  4'd1, 32'h0,         1'b1, '{32'h7FFF_FFFF, 1'b0}},
            '{OP_QUERY, 4'd1,  4'd0, 32'h0,         1'b0, '0},
            '{OP_QUERY, 4'd1,  4'd1, 32'h0,         1'b1, '{32'h7FFF_FFFF, 1'b1}},
            '{OP_WRITE, 4'd1,  4'd0, 32'h8000_0000, 1'b0, '0},
            '{OP_QUERY, 4'd1,  4'd1, 32'h0,         1'b1, '{32'h8000_0000, 1'b1}},
            '{OP_WRITE, 4'd0,  4'd0, 32'h0000_0001, 1'b0, '0},
            '{OP_WRITE, 4'd1,  4'd0, 32'hFFFF_8000, 1'b0, '0},
            '{OP_QUERY, 4'd1,  4'd0, 32'h0,         1'b0, '0},
            '{OP_WRITE, 4'd0,  4'd1, 32'hFFFF_8000, 1'b0, '0},
            '{OP_WRITE, 4'd1,  4'd1, 32'hFFFF_0000, 1'b0, '0},
            '{OP_QUERY, 4'd1,  4'd1, 32'h0,         1'b0, '0},
            '{OP_SIZE,  4'd0,  4'd0, 32'd2,         1'b0, '0},
            '{OP_QUERY, 4'd2,  4'd0, 32'h0,         1'b1, '{32'h0, 1'b0}},
            '{OP_WRITE, 4'd3,  4'd3, 32'h1234_5678, 1'b0, '0},
            '{OP_QUERY, 4'd1,  4'd1, 32'h0,         1'b0, '0},
            '{OP_SIZE,  4'd0,  4'd0, 32'd0,         1'b0, '0},
            '{OP_QUERY, 4'd0,  4'd1, 32'h0,         1'b1, '{32'h0, 1'b0}},
            '{OP_QUERY, 4'd0,  4'd0, 32'h0,         1'b0, '0},
            '{OP_SIZE,  4'd0,  4'd0, 32'd31,        1'b0, '0},
            '{OP_WRITE, 4'd15, 4'd0, 32'h0003_0000, 1'b0, '0},
            '{OP_QUERY, 4'd15, 4'd0, 32'h0,         1'b0, '0}
        };
        phase_sizes = '{5'd16, 5'd1, 5'd4, 5'd16, 5'd0, 5'd9, 5'd31, 5'd2, 5'd17, 5'd16,
                        5'd12};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: corner values, saturation, size corners, out-of-range requests.
        for (int i = 0; i < N_DIRECTED; i++) begin
            case (directed_rows[i].op)
                OP_SIZE:
                    program_size(directed_rows[i].value[SIZE_W-1:0]);
                OP_WRITE:
                    send_request(KIND_WRITE, directed_rows[i].row, directed_rows[i].col,
                                 directed_rows[i].value, 1'b0, '0);
                default:
                    send_request(KIND_QUERY, directed_rows[i].row, directed_rows[i].col,
                                 directed_rows[i].value, directed_rows[i].typed,
                                 directed_rows[i].result);
            endcase
        end

        // Random phases, each at the size given in phase_sizes; the fourth runs without any stalls.
        for (int p = 0; p < N_PHASES; p++) begin
            program_size(phase_sizes[p]);
            steady_run <= (p == 3);
            items_in_phase = 0;
            while (items_in_phase < PHASE_ITEMS) random_request();
        end
        steady_run <= 1'b0;

        // Drain and let any late result show up.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0 && pending_products.size() == 0) begin
            $display("[packed_lu_product] OK");
        end else begin
            $display("[packed_lu_product] ERROR");
        end
        $finish;
    end

endmodule
